/* rtl/shortest_path_distance_sum_assert.svh */
// Assertion macros used by the checker file.
`ifndef SHORTEST_PATH_DISTANCE_SUM_ASSERT_SVH
`define SHORTEST_PATH_DISTANCE_SUM_ASSERT_SVH

// Same-cycle implication, sampled on the block clock.
`define SPDS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock.
`define SPDS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/spds_pkg.sv */
package spds_pkg;

   // Largest graph the store holds
   localparam int MAX_NODES = 64;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int ADDR_W    = 2 * NODE_W;
   localparam int STORE_DEPTH = MAX_NODES * MAX_NODES;

   // Field widths
   localparam int CNT_W    = 7;
   localparam int WEIGHT_W = 31;
   localparam int DIST_W   = 37;
   localparam int SUM_W    = 43;

   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_NODES);
   localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

endpackage

/* rtl/spds_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
module spds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/spds_alu.sv */
// Shared add/compare unit: sum = a + b, lt = (a + b) < c.
// Used for the minimum scan, edge relaxation and the final accumulation.
module spds_alu (
   input  logic [spds_pkg::SUM_W-1:0]  a,
   input  logic [spds_pkg::DIST_W-1:0] b,
   input  logic [spds_pkg::SUM_W-1:0]  c,
   output logic [spds_pkg::SUM_W:0]    sum,
   output logic                        lt
);

   assign sum = {1'b0, a}
              + {{(spds_pkg::SUM_W + 1 - spds_pkg::DIST_W){1'b0}}, b};
   assign lt  = sum < {1'b0, c};

endmodule

/* rtl/shortest_path_distance_sum.sv */
// An item of the matrix is taken every cycle while busy is low; after the
// last of n * n items (n = active nodes) busy stays high while the one shared
// add/compare unit steps one node per cycle through the RAMs for the search.
// The result appears on rsp_valid for one cycle as busy falls; no back-pressure.
// Reset (synchronous, active high): node_count 64, load position zero, idle.
module shortest_path_distance_sum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [spds_pkg::WEIGHT_W-1:0] req_edge_weight,
   output logic                          rsp_valid,
   output logic [spds_pkg::SUM_W-1:0]    rsp_distance_sum,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [spds_pkg::CNT_W-1:0]    csr_node_count
);

   typedef enum logic [2:0] {
      IDLE,
      INIT,
      SCAN,
      RELAX,
      SUM
   } state_type;

   localparam int PAD_W = spds_pkg::SUM_W - spds_pkg::DIST_W;

   state_type                      state_ff, state_in;
   logic [spds_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [spds_pkg::NODE_W-1:0]    row_ff, row_in;
   logic [spds_pkg::NODE_W-1:0]    col_ff, col_in;
   logic [spds_pkg::NODE_W-1:0]    idx_ff, idx_in;
   logic [spds_pkg::NODE_W-1:0]    pidx_ff, pidx_in;
   logic [spds_pkg::NODE_W-1:0]    u_ff, u_in;
   logic                           iss_ff, iss_in;
   logic                           pend_ff, pend_in;
   logic                           found_ff, found_in;
   logic [spds_pkg::DIST_W-1:0]    best_ff, best_in;
   logic [spds_pkg::SUM_W-1:0]     acc_ff, acc_in;
   logic [spds_pkg::MAX_NODES-1:0] reached_ff, reached_in;
   logic [spds_pkg::MAX_NODES-1:0] settled_ff, settled_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [spds_pkg::SUM_W-1:0]     rsp_sum_ff, rsp_sum_in;

   logic                           accept;
   logic [spds_pkg::CNT_W-1:0]     n_eff;
   logic [spds_pkg::NODE_W-1:0]    nlast;
   logic                           phase_done;

   logic [spds_pkg::WEIGHT_W-1:0]  w_rd;
   logic [spds_pkg::DIST_W-1:0]    d_rd;
   logic                           d_we;
   logic [spds_pkg::NODE_W-1:0]    d_waddr;
   logic [spds_pkg::DIST_W-1:0]    d_wdata;

   logic [spds_pkg::SUM_W-1:0]     alu_a;
   logic [spds_pkg::DIST_W-1:0]    alu_b;
   logic [spds_pkg::SUM_W-1:0]     alu_c;
   logic [spds_pkg::SUM_W:0]       alu_sum;
   logic                           alu_lt;

   assign accept    = start && (state_ff == IDLE);
   assign busy      = (state_ff != IDLE);
   // count write only when idle and no item is offered in the same cycle
   assign csr_ready = (state_ff == IDLE) && !start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_distance_sum = rsp_sum_ff;

   // Clamp the node count into 1..MAX_NODES
   always_comb begin
      priority if (cnt_ff == '0) begin
         n_eff = spds_pkg::CNT_W'(1);
      end else if (cnt_ff > spds_pkg::CNT_W'(spds_pkg::MAX_NODES)) begin
         n_eff = spds_pkg::CNT_W'(spds_pkg::MAX_NODES);
      end else begin
         n_eff = cnt_ff;
      end
   end
   assign nlast = spds_pkg::NODE_W'(n_eff - spds_pkg::CNT_W'(1));

   // Weight matrix, addressed as {row, column}
   spds_ram #(
      .WIDTH (spds_pkg::WEIGHT_W),
      .DEPTH (spds_pkg::STORE_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr ({row_ff, col_ff}),
      .wr_data (req_edge_weight),
      .rd_addr ({u_ff, idx_ff}),
      .rd_data (w_rd)
   );

   // Tentative distance per node; validity lives in reached_ff
   spds_ram #(
      .WIDTH (spds_pkg::DIST_W),
      .DEPTH (spds_pkg::MAX_NODES)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_addr (idx_ff),
      .rd_data (d_rd)
   );

   // Operand select for the shared unit
   always_comb begin
      unique case (state_ff)
         SCAN: begin
            alu_a = {{PAD_W{1'b0}}, d_rd};
            alu_b = '0;
            alu_c = {{PAD_W{1'b0}}, best_ff};
         end
         RELAX: begin
            alu_a = {{PAD_W{1'b0}}, best_ff};
            alu_b = {{(spds_pkg::DIST_W - spds_pkg::WEIGHT_W){1'b0}}, w_rd};
            alu_c = {{PAD_W{1'b0}}, d_rd};
         end
         SUM: begin
            alu_a = acc_ff;
            alu_b = d_rd;
            alu_c = '0;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
            alu_c = '0;
         end
      endcase
   end

   spds_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .c   (alu_c),
      .sum (alu_sum),
      .lt  (alu_lt)
   );

   assign phase_done = !iss_ff && !pend_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      idx_in       = idx_ff;
      pidx_in      = idx_ff;
      u_in         = u_ff;
      iss_in       = iss_ff;
      pend_in      = iss_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      acc_in       = acc_ff;
      reached_in   = reached_ff;
      settled_in   = settled_ff;
      rsp_valid_in = 1'b0;
      rsp_sum_in   = rsp_sum_ff;
      d_we         = 1'b0;
      d_waddr      = pidx_ff;
      d_wdata      = alu_sum[spds_pkg::DIST_W-1:0];

      // Node index walk: one read issued per cycle, its data arriving in the next cycle
      if (iss_ff) begin
         if (idx_ff == nlast) begin
            iss_in = 1'b0;
         end else begin
            idx_in = idx_ff + spds_pkg::NODE_W'(1);
         end
      end

      unique case (state_ff)
         IDLE: begin
            iss_in  = 1'b0;
            pend_in = 1'b0;
            if (csr_valid && csr_ready) begin
               cnt_in = csr_node_count;
               row_in = '0;
               col_in = '0;
            end else if (accept) begin
               if (col_ff == nlast) begin
                  col_in = '0;
                  if (row_ff == nlast) begin
                     row_in   = '0;
                     state_in = INIT;
                  end else begin
                     row_in = row_ff + spds_pkg::NODE_W'(1);
                  end
               end else begin
                  col_in = col_ff + spds_pkg::NODE_W'(1);
               end
            end
         end
         INIT: begin
            d_we       = 1'b1;
            d_waddr    = '0;
            d_wdata    = '0;
            reached_in = spds_pkg::MAX_NODES'(1);
            settled_in = '0;
            found_in   = 1'b0;
            idx_in     = '0;
            iss_in     = 1'b1;
            pend_in    = 1'b0;
            state_in   = SCAN;
         end
         SCAN: begin
            // Keep the first unsettled reached node of least distance
            if (pend_ff && reached_ff[pidx_ff] && !settled_ff[pidx_ff]
                && (!found_ff || alu_lt)) begin
               found_in = 1'b1;
               best_in  = d_rd;
               u_in     = pidx_ff;
            end
            if (phase_done) begin
               idx_in  = '0;
               iss_in  = 1'b1;
               pend_in = 1'b0;
               if (found_ff) begin
                  settled_in[u_ff] = 1'b1;
                  state_in = RELAX;
               end else begin
                  acc_in   = '0;
                  state_in = SUM;
               end
            end
         end
         RELAX: begin
            // Lower the distance of each open neighbor of the settled node
            if (pend_ff && (pidx_ff != u_ff) && !settled_ff[pidx_ff]
                && (w_rd != '0) && (!reached_ff[pidx_ff] || alu_lt)) begin
               d_we = 1'b1;
               reached_in[pidx_ff] = 1'b1;
            end
            if (phase_done) begin
               idx_in   = '0;
               iss_in   = 1'b1;
               pend_in  = 1'b0;
               found_in = 1'b0;
               state_in = SCAN;
            end
         end
         SUM: begin
            // Saturating total over reached nodes
            if (pend_ff && reached_ff[pidx_ff]) begin
               acc_in = alu_sum[spds_pkg::SUM_W] ? spds_pkg::SUM_MAX
                                                 : alu_sum[spds_pkg::SUM_W-1:0];
            end
            if (phase_done) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= spds_pkg::CNT_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         iss_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         reached_ff   <= '0;
         settled_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         reached_ff   <= reached_in;
         settled_ff   <= settled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      pidx_ff    <= pidx_in;
      u_ff       <= u_in;
      best_ff    <= best_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

endmodule

/* rtl/spds_checker.sv */
`include "shortest_path_distance_sum_assert.svh"

// Port-level checks on the run/result sequencing.
module spds_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // A run only begins after an item was taken
   `SPDS_ASSERT_IMP(a_busy_after_item, $rose(busy), $past(start && !busy), "run began without an item")

   // The end of a run always delivers its result
   `SPDS_ASSERT_IMP(a_result_at_end, $fell(busy), rsp_valid, "run ended without a result")

   // A result is shown only once the block is free again
   `SPDS_ASSERT_IMP(a_result_idle, rsp_valid, !busy, "result while busy")

   // One result per run: never two in a row
   `SPDS_ASSERT_NEXT(a_single_result, rsp_valid, !rsp_valid, "result repeated")

endmodule

bind shortest_path_distance_sum spds_checker u_spds_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import spds_pkg::*;

   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int SETTLE_CYCLES = 16;
   // worst search time at the largest size, plus margin
   localparam int DRAIN_CYCLES  = MAX_NODES * (2 * MAX_NODES + 6) + MAX_NODES + 103;
   localparam int ITEM_TARGET   = 1780;
   localparam int SUM_TARGET    = 40;
   localparam bit [WEIGHT_W-1:0] WEIGHT_MAX = '1;
   localparam bit [CNT_W-1:0]    COUNT_TOP  = '1;

   // Tracks node count and load position, predicts one sum per full matrix
   class distance_scoreboard;
      bit [WEIGHT_W-1:0] weights [STORE_DEPTH];
      bit [CNT_W-1:0]    node_count;
      int unsigned       load_pos;
      bit [SUM_W-1:0]    expected_sums [$];
      int unsigned       failures;
      int unsigned       sums_checked;
      int unsigned       items_seen;
      int unsigned       count_writes;

      function new();
         node_count = CNT_RESET;
         load_pos   = 0;
      endfunction

      // zero acts as one, anything above the store size is clamped
      function int unsigned active_nodes();
         if (node_count == 0) return 1;
         if (node_count > MAX_NODES) return MAX_NODES;
         return node_count;
      endfunction

      // Dijkstra from node 0, linear min scan, ties to lowest index
      function bit [SUM_W-1:0] shortest_sum(int unsigned n);
         bit [DIST_W-1:0]   node_dist [MAX_NODES];
         bit                reached [MAX_NODES];
         bit                settled [MAX_NODES];
         bit [DIST_W-1:0]   best;
         bit [DIST_W-1:0]   cand;
         bit [WEIGHT_W-1:0] w;
         bit [SUM_W:0]      total;
         int                u;
         foreach (node_dist[i]) begin
            node_dist[i] = '0;
            reached[i]   = 1'b0;
            settled[i]   = 1'b0;
         end
         reached[0] = 1'b1;
         best = '0;
         for (int step = 0; step < n; step++) begin
            u = -1;
            for (int i = 0; i < n; i++) begin
               if (!settled[i] && reached[i] && (u < 0 || node_dist[i] < best)) begin
                  best = node_dist[i];
                  u = i;
               end
            end
            if (u < 0) break;
            settled[u] = 1'b1;
            for (int v = 0; v < n; v++) begin
               w = weights[u * n + v];
               if (v == u || settled[v] || w == 0) continue;
               cand = best + DIST_W'(w);
               if (!reached[v] || cand < node_dist[v]) begin
                  node_dist[v] = cand;
                  reached[v]   = 1'b1;
               end
            end
         end
         // unreachable nodes add nothing; sum saturates
         total = '0;
         for (int i = 0; i < n; i++) begin
            if (reached[i]) begin
               total = total + (SUM_W + 1)'(node_dist[i]);
               if (total > (SUM_W + 1)'(SUM_MAX)) total = (SUM_W + 1)'(SUM_MAX);
            end
         end
         return total[SUM_W-1:0];
      endfunction

      // a count write restarts the matrix load
      function void note_count(bit [CNT_W-1:0] value);
         node_count = value;
         load_pos   = 0;
         count_writes++;
      endfunction

      function void note_weight(bit [WEIGHT_W-1:0] w);
         int unsigned n;
         int unsigned cells;
         n = active_nodes();
         cells = n * n;
         items_seen++;
         if (load_pos >= cells) load_pos = 0;
         weights[load_pos] = w;
         load_pos++;
         if (load_pos == cells) begin
            load_pos = 0;
            expected_sums.push_back(shortest_sum(n));
         end
      endfunction

      function void check_sum(logic [SUM_W-1:0] actual);
         bit [SUM_W-1:0] want;
         if (expected_sums.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("ERROR %0t: distance sum %0d with no matrix pending", $time, actual);
            return;
         end
         want = expected_sums.pop_front();
         sums_checked++;
         if (actual !== want) begin
            failures++;
            if (failures <= 10)
               $display("ERROR %0t: distance sum expected %0d, got %0d", $time, want, actual);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [WEIGHT_W-1:0] req_edge_weight  = '0;
   logic                rsp_valid;
   logic [SUM_W-1:0]    rsp_distance_sum;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_node_count   = '0;

   distance_scoreboard sums = new();

   // sender state
   bit          sending     = 1'b0;
   int          burst_left  = 0;
   int unsigned sent_items  = 0;
   int unsigned matrices    = 0;
   int unsigned partials    = 0;
   int unsigned cur_nodes   = MAX_NODES;

   shortest_path_distance_sum DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_edge_weight  (req_edge_weight),
      .rsp_valid        (rsp_valid),
      .rsp_distance_sum (rsp_distance_sum),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_node_count   (csr_node_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("shortest_path_distance_sum test failed");
      $finish;
   end

   // Observe handshakes on the block's ports
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sums.note_count(csr_node_count);
         if (start && !busy) sums.note_weight(req_edge_weight);
         if (rsp_valid) sums.check_sum(rsp_distance_sum);
      end
   end

   task automatic stop_sending();
      if (sending) begin
         start <= 1'b0;
         sending = 1'b0;
      end
   endtask

   // one item, then maybe a gap when the burst runs out
   task automatic send_weight(input bit [WEIGHT_W-1:0] w);
      if (!sending) begin
         start <= 1'b1;
         sending = 1'b1;
      end
      req_edge_weight <= w;
      do @(posedge clock); while (busy !== 1'b0);
      sent_items++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         stop_sending();
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(0, 15);
      end
   endtask

   // stop sending, let the monitor note the last accepted item, then wait for every pending sum
   task automatic wait_drained();
      stop_sending();
      @(posedge clock);
      while (sums.expected_sums.size() != 0) @(posedge clock);
   endtask

   // count write only with the block idle and nothing outstanding
   task automatic write_count(input bit [CNT_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_node_count <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      cur_nodes = (value == 0) ? 1 : (value > MAX_NODES) ? MAX_NODES : value;
   endtask

   // density in percent; scale picks tiny, moderate, full-range or near-max weights
   function automatic bit [WEIGHT_W-1:0] pick_weight(int density, int scale);
      bit [WEIGHT_W-1:0] w;
      if ($urandom_range(0, 99) >= density) return '0;
      case (scale)
         0: w = WEIGHT_W'($urandom_range(1, 8));
         1: w = WEIGHT_W'($urandom_range(1, 1000));
         2: begin
            w = WEIGHT_W'($urandom);
            if (w == 0) w = 1;
         end
         default: w = WEIGHT_MAX - WEIGHT_W'($urandom_range(0, 3));
      endcase
      return w;
   endfunction

   task automatic send_matrix(input int unsigned n);
      int density;
      int scale;
      density = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                            : $urandom_range(20, 70);
      scale = $urandom_range(0, 3);
      for (int c = 0; c < n * n; c++) send_weight(pick_weight(density, scale));
      matrices++;
   endtask

   initial begin
      bit [CNT_W-1:0] count;
      int             pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // partial load at the reset size, dropped by the count write
      for (int i = 0; i < 5; i++) send_weight(WEIGHT_MAX >> i);
      partials++;

      // single node: every item is a full matrix, sum is zero
      write_count(1);
      send_weight('0);
      send_weight(WEIGHT_MAX);
      send_weight(1);
      // count of zero acts as one
      write_count('0);
      send_weight(31'h2AAA_AAAA);

      // two nodes: ignored self-loop, max edge; then node 1 unreachable
      write_count(2);
      send_weight(WEIGHT_MAX);
      send_weight(WEIGHT_MAX);
      send_weight('0);
      send_weight(5);
      wait_drained();
      send_weight(3);
      send_weight('0);
      send_weight(7);
      send_weight('0);

      // three nodes: indirect path beats the direct edge
      write_count(3);
      send_weight('0);  send_weight(10); send_weight(3);
      send_weight(2);   send_weight('0); send_weight('0);
      send_weight('0);  send_weight(4);  send_weight(9);

      // Random phases: mostly small graphs, some dropped partial loads
      while (sent_items < ITEM_TARGET || matrices < SUM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 5)       count = '0;
         else if (pick < 15) count = 1;
         else if (pick < 75) count = CNT_W'($urandom_range(2, 6));
         else if (pick < 95) count = CNT_W'($urandom_range(7, 10));
         else                count = CNT_W'($urandom_range(11, 16));
         write_count(count);
         repeat ($urandom_range(1, 4)) begin
            send_matrix(cur_nodes);
            if ($urandom_range(0, 5) == 0) wait_drained();
         end
         if (cur_nodes > 1 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, cur_nodes * cur_nodes - 1))
               send_weight(pick_weight(50, $urandom_range(0, 3)));
            partials++;
         end
      end

      // count with every bit set clamps to the largest graph; a short load gives no sum
      write_count(COUNT_TOP);
      repeat (40) send_weight(pick_weight(50, $urandom_range(0, 3)));
      partials++;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sums.expected_sums.size() != 0) begin
         sums.failures++;
         $display("ERROR: %0d distance sums never arrived", sums.expected_sums.size());
      end

      $display("Covered %0d weight items in %0d matrices and %0d count writes,",
               sums.items_seen, matrices, sums.count_writes);
      $display("  %0d distance sums checked, %0d partial loads dropped, %0d failures",
               sums.sums_checked, partials, sums.failures);
      if (sums.failures == 0) begin
         $display("shortest_path_distance_sum test passed");
      end else begin
         $display("shortest_path_distance_sum test failed");
      end
      $finish;
   end

endmodule
